>>> src/first_fit_page_allocator_assert.svh
// Assertion macros shared by the checker of the first-fit page allocator.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Checked at every edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("first-fit allocator check failed");

// Checked only outside reset.
`define FPA_ASSERT_RUN(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("first-fit allocator check failed");

`endif

>>> src/fpa_pkg.sv
// Package of constants, codes and payload types of the first-fit page allocator.
`default_nettype none
package fpa_pkg;
   localparam int MAX_EXTENTS     = 64;
   localparam int PAGE_INDEX_BITS = 20;
   localparam int LEN_BITS        = PAGE_INDEX_BITS + 1;
   localparam int IDX_BITS        = $clog2(MAX_EXTENTS);
   localparam int USED_BITS       = $clog2(MAX_EXTENTS + 1);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]                 op;
      logic [PAGE_INDEX_BITS-1:0] start_page;
      logic [LEN_BITS-1:0]        page_count;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [PAGE_INDEX_BITS-1:0] block_start;
      logic [LEN_BITS-1:0]        free_count;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_INDEX_BITS-1:0] start;
      logic [LEN_BITS-1:0]        len;
   } extent_type;
endpackage
`default_nettype wire

>>> src/first_fit_page_allocator.sv
// A rejected or ignored transaction goes from acceptance straight to the done state; any other
// first scans the whole chain, and its result is registered from the done state.
// One transaction is taken at a time: the next is accepted only once the result is registered,
// later while a result waits, as a scan is one full rotation of the chain.
// Reset empties the table and clears the free count at once; no clearing pass.
// The extent cells themselves are not reset.
`default_nettype none
module first_fit_page_allocator (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  fpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output fpa_pkg::rsp_type rsp_data
);
   import fpa_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [1:0] M_COPY = 2'd0;
   localparam logic [1:0] M_SKIP = 2'd1;
   localparam logic [1:0] M_INS  = 2'd2;
   localparam logic [1:0] M_MODN = 2'd3;

   localparam logic [IDX_BITS-1:0] K_LAST = IDX_BITS'(MAX_EXTENTS - 1);
   localparam logic [LEN_BITS-1:0] SPACE  = LEN_BITS'(1) << PAGE_INDEX_BITS;

   logic [1:0]                 state_ff, state_in;
   logic [1:0]                 mode_ff, mode_in;
   logic [1:0]                 op_ff, op_in;
   logic [PAGE_INDEX_BITS-1:0] base_ff, base_in;
   logic [LEN_BITS-1:0]        n_ff, n_in;
   logic [IDX_BITS-1:0]        k_ff, k_in;
   logic                       done_ff, done_in;
   extent_type                 carry_ff, carry_in;
   logic [USED_BITS-1:0]       used_ff, used_in;
   logic [LEN_BITS-1:0]        total_ff, total_in;
   logic [1:0]                 status_ff, status_in;
   logic [PAGE_INDEX_BITS-1:0] block_ff, block_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   extent_type cell_q [MAX_EXTENTS];
   extent_type emit;
   logic       shift_en;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
         if (gi == MAX_EXTENTS - 1) begin : g_tail
            fpa_cell u_cell (.clock(clock), .shift_en(shift_en), .ext_in(emit),
                             .ext_out(cell_q[gi]));
         end else begin : g_body
            fpa_cell u_cell (.clock(clock), .shift_en(shift_en), .ext_in(cell_q[gi+1]),
                             .ext_out(cell_q[gi]));
         end
      end
   endgenerate

   extent_type                 head, nxt;
   logic                       in_used, nxt_in, slot0, slotk, lo, up, merge;
   logic [LEN_BITS:0]          total_sum, head_end, new_end;
   logic [LEN_BITS-1:0]        rem, total_add;
   logic [USED_BITS-1:0]       k_ext;

   assign head = cell_q[0];
   assign nxt  = cell_q[1];
   assign k_ext   = USED_BITS'(k_ff);
   assign in_used = k_ext < used_ff;
   assign nxt_in  = (k_ext + USED_BITS'(1)) < used_ff;
   assign merge   = (op_ff == OP_FREE);
   assign head_end = {2'b00, head.start} + {1'b0, head.len};
   assign new_end  = {2'b00, base_ff} + {1'b0, n_ff};
   assign total_sum = {1'b0, total_ff} + {1'b0, n_ff};
   assign total_add = total_sum[LEN_BITS] ? {LEN_BITS{1'b1}} : total_sum[LEN_BITS-1:0];
   assign rem = SPACE - {1'b0, req_data.start_page};
   assign slot0 = (k_ff == '0) && ((used_ff == '0) || (head.start > base_ff));
   assign slotk = in_used && (head.start <= base_ff) && (!nxt_in || (nxt.start > base_ff));
   assign lo = merge && (head_end == {2'b00, base_ff});
   assign up = merge && (new_end == {2'b00, nxt.start}) && nxt_in;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      op_in        = op_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      done_in      = done_ff;
      carry_in     = carry_ff;
      used_in      = used_ff;
      total_in     = total_ff;
      status_in    = status_ff;
      block_in     = block_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      shift_en     = 1'b0;
      emit         = head;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               base_in   = req_data.start_page;
               n_in      = req_data.page_count;
               k_in      = '0;
               mode_in   = M_COPY;
               done_in   = 1'b0;
               block_in  = '0;
               status_in = ST_OK;
               state_in  = S_SCAN;
               if ((req_data.op != OP_ALLOC) && (req_data.page_count > rem)) begin
                  n_in = rem;
               end
               if (req_data.op == OP_NONE) begin
                  state_in = S_DONE;
               end else if (req_data.page_count == '0) begin
                  status_in = ST_ZERO;
                  state_in  = S_DONE;
               end else if (req_data.op == OP_ALLOC) begin
                  status_in = ST_NOFIT;
                  if (req_data.page_count > total_ff) begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_SCAN: begin
            shift_en = 1'b1;
            k_in     = k_ff + IDX_BITS'(1);
            case (mode_ff)
               M_COPY: emit = head;
               M_SKIP: emit = nxt;
               M_INS: begin
                  emit     = carry_ff;
                  carry_in = head;
               end
               M_MODN: begin
                  emit    = '{start: base_ff, len: head.len + n_ff};
                  mode_in = M_COPY;
               end
               default: emit = head;
            endcase
            if (!done_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (in_used && (head.len >= n_ff)) begin
                     done_in   = 1'b1;
                     block_in  = head.start;
                     status_in = ST_OK;
                     total_in  = total_ff - n_ff;
                     if (head.len > n_ff) begin
                        emit = '{start: head.start + PAGE_INDEX_BITS'(n_ff),
                                 len: head.len - n_ff};
                     end else begin
                        emit    = nxt;
                        mode_in = M_SKIP;
                        used_in = used_ff - USED_BITS'(1);
                     end
                  end
               end else if (slot0) begin
                  // The new extent belongs ahead of every stored one.
                  done_in = 1'b1;
                  if (merge && (new_end == {2'b00, head.start}) && (used_ff != '0)) begin
                     emit     = '{start: base_ff, len: head.len + n_ff};
                     total_in = total_add;
                  end else if (used_ff == USED_BITS'(MAX_EXTENTS)) begin
                     status_in = ST_FULL;
                  end else begin
                     emit     = '{start: base_ff, len: n_ff};
                     carry_in = head;
                     mode_in  = M_INS;
                     used_in  = used_ff + USED_BITS'(1);
                     total_in = total_add;
                  end
               end else if (slotk) begin
                  // The head is the last extent starting at or below the base.
                  done_in = 1'b1;
                  if (lo && up) begin
                     emit     = '{start: head.start, len: head.len + n_ff + nxt.len};
                     mode_in  = M_SKIP;
                     used_in  = used_ff - USED_BITS'(1);
                     total_in = total_add;
                  end else if (lo) begin
                     emit     = '{start: head.start, len: head.len + n_ff};
                     total_in = total_add;
                  end else if (up) begin
                     mode_in  = M_MODN;
                     total_in = total_add;
                  end else if (used_ff == USED_BITS'(MAX_EXTENTS)) begin
                     status_in = ST_FULL;
                  end else begin
                     carry_in = '{start: base_ff, len: n_ff};
                     mode_in  = M_INS;
                     used_in  = used_ff + USED_BITS'(1);
                     total_in = total_add;
                  end
               end
            end
            if (k_ff == K_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_ff, block_start: block_ff,
                                free_count: total_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_COPY;
         done_ff      <= 1'b0;
         k_ff         <= '0;
         used_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         done_ff      <= done_in;
         k_ff         <= k_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      base_ff   <= base_in;
      n_ff      <= n_in;
      carry_ff  <= carry_in;
      status_ff <= status_in;
      block_ff  <= block_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

>>> src/fpa_cell.sv
// One cell of the extent chain: holds one extent and takes its neighbour's on a shift.
`default_nettype none
module fpa_cell (
   input  wire                  clock,
   input  wire                  shift_en,
   input  fpa_pkg::extent_type  ext_in,
   output fpa_pkg::extent_type  ext_out
);
   import fpa_pkg::*;

   extent_type ext_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         ext_ff <= ext_in;
      end
   end

   assign ext_out = ext_ff;
endmodule
`default_nettype wire

>>> src/fpa_checker.sv
// Port-level checker of the first-fit page allocator, bound to the top level.
`default_nettype none
`include "first_fit_page_allocator_assert.svh"
module fpa_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input fpa_pkg::rsp_type rsp_data
);
   import fpa_pkg::*;

   // A stalled result transaction keeps its payload.
   `FPA_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp_data)))
   // A result with a status other than OK reports a block start of zero.
   `FPA_ASSERT_RUN(a_block_zero, rsp_valid && (rsp_data.status != ST_OK),
                   rsp_data.block_start == '0)
   // One transaction is worked on at a time.
   `FPA_ASSERT_RUN(a_one_at_a_time, req_valid && req_ready, ##1 !req_ready)
   // Reset leaves no result pending.
   `FPA_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid)
endmodule

bind first_fit_page_allocator fpa_checker u_fpa_checker (.*);
`default_nettype wire
